/* design/sdinit_pkg.sv */
// Shared types, constants and helpers of the SD card initialisation sequencer.
`default_nettype none
package sdinit_pkg;

   localparam logic [31:0] OP_COND_RESET = 32'h4030_0000;

   localparam logic        MODE_START    = 1'b0;
   localparam logic        MODE_COMPLETE = 1'b1;

   localparam logic        KIND_ISSUE    = 1'b0;
   localparam logic        KIND_DONE     = 1'b1;

   localparam logic [1:0]  STATUS_OK       = 2'd0;
   localparam logic [1:0]  STATUS_IF_FAIL  = 2'd1;
   localparam logic [1:0]  STATUS_APP_FAIL = 2'd2;
   localparam logic [1:0]  STATUS_ID_FAIL  = 2'd3;

   localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0]  CMD_ALL_CID   = 6'd2;
   localparam logic [5:0]  CMD_SEND_RCA  = 6'd3;
   localparam logic [5:0]  CMD_SELECT    = 6'd7;
   localparam logic [5:0]  CMD_IF_COND   = 6'd8;
   localparam logic [5:0]  CMD_SEND_CSD  = 6'd9;
   localparam logic [5:0]  CMD_BLOCKLEN  = 6'd16;
   localparam logic [5:0]  CMD_OP_COND   = 6'd41;
   localparam logic [5:0]  CMD_APP       = 6'd55;

   localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
   localparam logic [7:0]  ECHO_PATTERN  = 8'hAA;
   localparam int unsigned APP_CMD_BIT   = 5;
   localparam int unsigned BUSY_BIT      = 31;
   localparam logic [31:0] BLOCK_LENGTH  = 32'd512;

   localparam logic [1:0]  CSD_V1 = 2'd0;
   localparam logic [1:0]  CSD_V2 = 2'd1;

   typedef struct packed {
      logic        mode;
      logic        command_ok;
      logic [31:0] response_word0;
      logic [31:0] response_word1;
      logic [31:0] response_word2;
      logic [31:0] response_word3;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_argument;
      logic        response_expected;
      logic        long_response;
      logic        check_crc;
      logic [1:0]  status_code;
      logic [15:0] card_address;
      logic [32:0] block_count;
   } rsp_item_type;

   function automatic rsp_item_type make_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                             input logic resp, input logic lng,
                                             input logic crc);
      rsp_item_type r;
      r                   = '0;
      r.kind              = KIND_ISSUE;
      r.cmd_index         = idx;
      r.cmd_argument      = arg;
      r.response_expected = resp;
      r.long_response     = lng;
      r.check_crc         = crc;
      r.status_code       = STATUS_OK;
      return r;
   endfunction

   function automatic rsp_item_type make_done(input logic [1:0] status);
      rsp_item_type r;
      r             = '0;
      r.kind        = KIND_DONE;
      r.status_code = status;
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/sdinit_req_if.sv */
// Request channel of the sequencer: valid/ready handshake and request fields.
`default_nettype none
interface sdinit_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic        command_ok;
   logic [31:0] response_word0;
   logic [31:0] response_word1;
   logic [31:0] response_word2;
   logic [31:0] response_word3;

   modport source (output valid, mode, command_ok, response_word0, response_word1,
                   response_word2, response_word3, input ready);
   modport sink   (input valid, mode, command_ok, response_word0, response_word1,
                   response_word2, response_word3, output ready);
endinterface
`default_nettype wire

/* design/sdinit_rsp_if.sv */
// Result channel of the sequencer: valid/ready handshake and result fields.
`default_nettype none
interface sdinit_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [5:0]  cmd_index;
   logic [31:0] cmd_argument;
   logic        response_expected;
   logic        long_response;
   logic        check_crc;
   logic [1:0]  status_code;
   logic [15:0] card_address;
   logic [32:0] block_count;

   modport source (output valid, kind, cmd_index, cmd_argument, response_expected,
                   long_response, check_crc, status_code, card_address, block_count,
                   input ready);
   modport sink   (input valid, kind, cmd_index, cmd_argument, response_expected,
                   long_response, check_crc, status_code, card_address, block_count,
                   output ready);
endinterface
`default_nettype wire

/* design/sdinit_csd.sv */
// CSD capacity decoder: card size in 512-byte blocks for structure v1 and v2.
`default_nettype none
module sdinit_csd
   import sdinit_pkg::*;
(
   input  wire logic [31:0] csd_word1,
   input  wire logic [31:0] csd_word2,
   input  wire logic [31:0] csd_word3,
   output logic      [32:0] block_count
);

   logic [1:0]  structure;
   logic [12:0] v1_size;
   logic [4:0]  v1_shift;
   logic [41:0] v1_wide;
   logic [22:0] v2_size;

   always_comb begin
      structure = csd_word3[31:30];
      v1_size   = {1'b0, csd_word2[9:0], csd_word1[31:30]} + 13'd1;
      // (size+1) << (mult+2) << read_bl_len, then / 512
      v1_shift  = {2'b00, csd_word1[17:15]} + 5'd2 + {1'b0, csd_word2[19:16]};
      v1_wide   = {29'd0, v1_size} << v1_shift;
      v2_size   = {1'b0, csd_word2[5:0], csd_word1[31:16]} + 23'd1;
      unique case (structure)
         CSD_V1:  block_count = v1_wide[41:9];
         CSD_V2:  block_count = {v2_size, 10'd0};
         default: block_count = '0;
      endcase
   end

endmodule
`default_nettype wire

/* design/sdinit_fsm.sv */
// Command sequencing state machine with stored card data and result register.
`default_nettype none
module sdinit_fsm
   import sdinit_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire req_item_type item,
   input  wire logic [31:0]  op_cond_arg,
   input  wire logic [32:0]  csd_count,
   output logic              stage_free,
   sdinit_rsp_if.source      rsp_bus
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41,
      PH_CMD2, PH_CMD3, PH_CMD9, PH_CMD7, PH_CMD16
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [15:0]  addr_ff, addr_in;
   logic [32:0]  count_ff, count_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic         emit;
   logic         take;
   logic [31:0]  w0;

   assign stage_free = !rsp_valid_ff || rsp_bus.ready;
   assign take       = item_valid && stage_free;

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      emit     = 1'b1;
      rsp_in   = '0;
      w0       = item.command_ok ? item.response_word0 : '0;
      if (item.mode == MODE_START) begin
         addr_in  = '0;
         count_in = '0;
         phase_in = PH_CMD0;
         rsp_in   = make_cmd(CMD_GO_IDLE, '0, 1'b0, 1'b0, 1'b0);
      end else begin
         unique case (phase_ff)
            PH_CMD0: begin
               phase_in = PH_CMD8;
               rsp_in   = make_cmd(CMD_IF_COND, IF_COND_ARG, 1'b1, 1'b0, 1'b1);
            end
            PH_CMD8: begin
               if ((w0[7:0] & ECHO_PATTERN) != ECHO_PATTERN) begin
                  phase_in = PH_IDLE;
                  rsp_in   = make_done(STATUS_IF_FAIL);
               end else begin
                  phase_in = PH_CMD55;
                  rsp_in   = make_cmd(CMD_APP, '0, 1'b1, 1'b0, 1'b1);
               end
            end
            PH_CMD55: begin
               if (!w0[APP_CMD_BIT]) begin
                  phase_in = PH_IDLE;
                  rsp_in   = make_done(STATUS_APP_FAIL);
               end else begin
                  phase_in = PH_ACMD41;
                  rsp_in   = make_cmd(CMD_OP_COND, op_cond_arg, 1'b1, 1'b0, 1'b0);
               end
            end
            PH_ACMD41: begin
               if (w0[BUSY_BIT]) begin
                  phase_in = PH_CMD2;
                  rsp_in   = make_cmd(CMD_ALL_CID, '0, 1'b1, 1'b1, 1'b1);
               end else begin
                  phase_in = PH_CMD55;
                  rsp_in   = make_cmd(CMD_APP, '0, 1'b1, 1'b0, 1'b1);
               end
            end
            PH_CMD2: begin
               if (!item.command_ok) begin
                  phase_in = PH_IDLE;
                  rsp_in   = make_done(STATUS_ID_FAIL);
               end else begin
                  phase_in = PH_CMD3;
                  rsp_in   = make_cmd(CMD_SEND_RCA, '0, 1'b1, 1'b0, 1'b1);
               end
            end
            PH_CMD3: begin
               addr_in  = w0[31:16];
               phase_in = PH_CMD9;
               rsp_in   = make_cmd(CMD_SEND_CSD, {w0[31:16], 16'd0}, 1'b1, 1'b1, 1'b1);
            end
            PH_CMD9: begin
               count_in = csd_count;
               phase_in = PH_CMD7;
               rsp_in   = make_cmd(CMD_SELECT, {addr_ff, 16'd0}, 1'b1, 1'b0, 1'b1);
            end
            PH_CMD7: begin
               phase_in = PH_CMD16;
               rsp_in   = make_cmd(CMD_BLOCKLEN, BLOCK_LENGTH, 1'b1, 1'b0, 1'b1);
            end
            PH_CMD16: begin
               phase_in = PH_IDLE;
               rsp_in   = make_done(STATUS_OK);
            end
            PH_IDLE: begin
               emit = 1'b0;
            end
            default: begin
               phase_in = PH_IDLE;
               emit     = 1'b0;
            end
         endcase
      end
      rsp_in.card_address = addr_in;
      rsp_in.block_count  = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         addr_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= emit;
         rsp_ff       <= rsp_in;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.kind              = rsp_ff.kind;
   assign rsp_bus.cmd_index         = rsp_ff.cmd_index;
   assign rsp_bus.cmd_argument      = rsp_ff.cmd_argument;
   assign rsp_bus.response_expected = rsp_ff.response_expected;
   assign rsp_bus.long_response     = rsp_ff.long_response;
   assign rsp_bus.check_crc         = rsp_ff.check_crc;
   assign rsp_bus.status_code       = rsp_ff.status_code;
   assign rsp_bus.card_address      = rsp_ff.card_address;
   assign rsp_bus.block_count       = rsp_ff.block_count;

endmodule
`default_nettype wire

/* design/sd_card_init_sequencer.sv */
// Top level of the SD card initialisation sequencer.
//
//   channel   direction  contents
//   req_bus   in         start or completion request with response words
//   rsp_bus   out        next command to issue, or final status
//   csr_*     in         ACMD41 operating condition argument
//
// A request reaches the result through the input register, then the result register.
// One request per cycle is accepted; the result register holds while rsp_bus
// stalls, and the input register fills behind it before req_bus.ready drops.
// Completions with no command outstanding give no result.
// Synchronous reset returns to idle and clears card address and block count.
`default_nettype none
module sd_card_init_sequencer
   import sdinit_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   sdinit_req_if.sink       req_bus,
   sdinit_rsp_if.source     rsp_bus
);

   logic         op_cond_ff;
   logic [31:0]  op_cond_arg_ff;
   logic         req_valid_ff;
   req_item_type req_ff;
   req_item_type req_in;
   logic         stage_free;
   logic [32:0]  csd_count;
   logic [31:0]  csd_w1, csd_w2, csd_w3;

   assign req_bus.ready = !req_valid_ff || stage_free;

   always_comb begin
      req_in.mode           = req_bus.mode;
      req_in.command_ok     = req_bus.command_ok;
      req_in.response_word0 = req_bus.response_word0;
      req_in.response_word1 = req_bus.response_word1;
      req_in.response_word2 = req_bus.response_word2;
      req_in.response_word3 = req_bus.response_word3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_cond_ff     <= 1'b0;
         op_cond_arg_ff <= OP_COND_RESET;
         req_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            op_cond_ff     <= 1'b1;
            op_cond_arg_ff <= csr_write_data;
         end
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_ff <= req_in;
      end
   end

   // failed commands read as all-zero responses
   assign csd_w1 = req_ff.command_ok ? req_ff.response_word1 : '0;
   assign csd_w2 = req_ff.command_ok ? req_ff.response_word2 : '0;
   assign csd_w3 = req_ff.command_ok ? req_ff.response_word3 : '0;

   sdinit_csd u_csd (
      .csd_word1   (csd_w1),
      .csd_word2   (csd_w2),
      .csd_word3   (csd_w3),
      .block_count (csd_count)
   );

   sdinit_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_valid_ff),
      .item        (req_ff),
      .op_cond_arg (op_cond_ff ? op_cond_arg_ff : OP_COND_RESET),
      .csd_count   (csd_count),
      .stage_free  (stage_free),
      .rsp_bus     (rsp_bus)
   );

endmodule
`default_nettype wire
